/* sv/pfbd_pkg.sv */
package pfbd_pkg;

  localparam int unsigned HeaderBytes   = 16;
  localparam int unsigned TrailerBytes  = 8;
  localparam int unsigned OverheadBytes = HeaderBytes + TrailerBytes;
  localparam int unsigned PosWidth      = 33;
  localparam int unsigned MaxWidth      = 24;

  localparam logic [7:0] StartPattern [8] = '{
    8'hAA, 8'hD6, 8'h3E, 8'h69, 8'h02, 8'h5A, 8'h7F, 8'h55
  };
  localparam logic [7:0] EndPattern [8] = '{
    8'h55, 8'h7F, 8'h5A, 8'h02, 8'h69, 8'h3E, 8'hD6, 8'hAA
  };

  localparam int unsigned FlagStart    = 0;
  localparam int unsigned FlagSequence = 1;
  localparam int unsigned FlagOversize = 2;
  localparam int unsigned FlagEnd      = 3;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic        start_error;
    logic        sequence_error;
    logic        oversize_error;
    logic        end_error;
    logic [31:0] frame_sequence;
    logic [31:0] payload_length;
  } result_t;

endpackage

/* sv/pattern_framed_block_deframer_core.sv */
// Deframer for a byte stream of framed blocks: 8-byte start pattern, big-endian
// 32-bit payload length and sequence number, payload, then an 8-byte end pattern.
// One byte beat is accepted per clock while the output is not stalled; each byte
// passes the input register and the single parsing stage, and its result is
// held in the result register. Payload bytes come out one per result, and the
// final byte of a frame gives a status result with the header fields and four
// error flags. Errors only raise flags and never shorten a frame, and there is no
// resynchronization. Write max_frame_bytes only while the block is idle.
module pattern_framed_block_deframer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          max_frame_bytes_we_i,
  input  logic [pfbd_pkg::MaxWidth-1:0] max_frame_bytes_i,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    stream_byte_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    payload_byte_o,
  output logic                          payload_valid_o,
  output logic                          frame_done_o,
  output logic                          start_error_o,
  output logic                          sequence_error_o,
  output logic                          oversize_error_o,
  output logic                          end_error_o,
  output logic [31:0]                   frame_sequence_o,
  output logic [31:0]                   payload_length_o
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              out_free;
  logic              advance;
  logic              res_valid;
  pfbd_pkg::result_t res_comb;
  pfbd_pkg::result_t res_out;

  assign advance = held_valid && out_free;

  pfbd_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .stream_byte_i (stream_byte_i),
    .advance_i     (advance),
    .held_valid_o  (held_valid),
    .held_byte_o   (held_byte)
  );

  pfbd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (max_frame_bytes_we_i),
    .cfg_wdata_i (max_frame_bytes_i),
    .step_i      (advance),
    .byte_i      (held_byte),
    .res_valid_o (res_valid),
    .res_o       (res_comb)
  );

  pfbd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res_comb),
    .out_stall_i (out_stall),
    .free_o      (out_free),
    .out_valid_o (out_valid),
    .res_o       (res_out)
  );

  assign payload_byte_o   = res_out.payload_byte;
  assign payload_valid_o  = res_out.payload_valid;
  assign frame_done_o     = res_out.frame_done;
  assign start_error_o    = res_out.start_error;
  assign sequence_error_o = res_out.sequence_error;
  assign oversize_error_o = res_out.oversize_error;
  assign end_error_o      = res_out.end_error;
  assign frame_sequence_o = res_out.frame_sequence;
  assign payload_length_o = res_out.payload_length;

endmodule

/* sv/pfbd_in_stage.sv */
module pfbd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  input  logic       advance_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = stream_byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

endmodule

/* sv/pfbd_parser.sv */
module pfbd_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfbd_pkg::MaxWidth-1:0]   cfg_wdata_i,
  input  logic                            step_i,
  input  logic [7:0]                      byte_i,
  output logic                            res_valid_o,
  output pfbd_pkg::result_t               res_o
);

  localparam int unsigned PW = pfbd_pkg::PosWidth;
  localparam int unsigned MW = pfbd_pkg::MaxWidth;

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [PW-1:0] plast_q, plast_d;
  logic [31:0]   len_q, len_d;
  logic [31:0]   seq_q, seq_d;
  logic [31:0]   last_q, last_d;
  logic [3:0]    flags_q, flags_d;
  logic [MW-1:0] max_q;

  logic [31:0]   seq_next;
  logic [2:0]    end_idx;
  logic [PW-1:0] frame_len;

  assign seq_next  = {seq_q[23:0], byte_i};
  assign end_idx   = pos_q[2:0] - pend_q[2:0];
  assign frame_len = {1'b0, len_q} + PW'(pfbd_pkg::OverheadBytes);

  always_comb begin
    pos_d       = pos_q;
    pend_d      = pend_q;
    plast_d     = plast_q;
    len_d       = len_q;
    seq_d       = seq_q;
    last_d      = last_q;
    flags_d     = flags_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      pos_d = pos_q + PW'(1);
      if (pos_q < PW'(pfbd_pkg::HeaderBytes)) begin
        if (pos_q[3:0] == 4'd0) begin
          flags_d = '0;
        end
        if (pos_q[3] == 1'b0) begin
          if (byte_i != pfbd_pkg::StartPattern[pos_q[2:0]]) begin
            flags_d[pfbd_pkg::FlagStart] = 1'b1;
          end
        end else if (pos_q[2] == 1'b0) begin
          len_d = {len_q[23:0], byte_i};
        end else begin
          seq_d = seq_next;
          if (pos_q[1:0] == 2'b11) begin
            pend_d  = {1'b0, len_q} + PW'(pfbd_pkg::HeaderBytes);
            plast_d = {1'b0, len_q} + PW'(pfbd_pkg::OverheadBytes - 1);
            if (seq_next != last_q + 32'd1) begin
              flags_d[pfbd_pkg::FlagSequence] = 1'b1;
            end
            if (frame_len > {{(PW-MW){1'b0}}, max_q}) begin
              flags_d[pfbd_pkg::FlagOversize] = 1'b1;
            end
            last_d = seq_next;
          end
        end
      end else if (pos_q < pend_q) begin
        res_valid_o         = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_valid = 1'b1;
      end else begin
        if (byte_i != pfbd_pkg::EndPattern[end_idx]) begin
          flags_d[pfbd_pkg::FlagEnd] = 1'b1;
        end
        if (pos_q >= plast_q) begin
          pos_d                = '0;
          res_valid_o          = 1'b1;
          res_o.frame_done     = 1'b1;
          res_o.start_error    = flags_d[pfbd_pkg::FlagStart];
          res_o.sequence_error = flags_d[pfbd_pkg::FlagSequence];
          res_o.oversize_error = flags_d[pfbd_pkg::FlagOversize];
          res_o.end_error      = flags_d[pfbd_pkg::FlagEnd];
          res_o.frame_sequence = seq_q;
          res_o.payload_length = len_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pend_q  <= '0;
      plast_q <= '0;
      len_q   <= '0;
      seq_q   <= '0;
      last_q  <= '0;
      flags_q <= '0;
      max_q   <= MW'(65536);
    end else begin
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      plast_q <= plast_d;
      len_q   <= len_d;
      seq_q   <= seq_d;
      last_q  <= last_d;
      flags_q <= flags_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* sv/pfbd_out_stage.sv */
module pfbd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  pfbd_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              free_o,
  output logic              out_valid_o,
  output pfbd_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  pfbd_pkg::result_t res_q, res_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (free_o) begin
      valid_d = load_i && res_valid_i;
      if (load_i && res_valid_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
